FILE: hdl/sacr_pkg.sv
package sacr_pkg;

  localparam int HIT_W = 32;
  localparam int LFSR_W = 16;
  localparam logic [HIT_W-1:0] HIT_MAX = '1;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_DATA   = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } victim_ctl_t;

endpackage

FILE: hdl/sacr_if.sv
interface sacr_req_if #(
  parameter int ADDR_BITS = 40,
  parameter int DATA_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [ADDR_BITS-1:0] address;
  logic [DATA_BITS-1:0] write_data;

  modport source (output valid, op, address, write_data, input ready);
  modport sink (input valid, op, address, write_data, output ready);
endinterface

interface sacr_rsp_if #(
  parameter int DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [DATA_BITS-1:0]        read_data;
  logic [2:0]                  way_used;
  logic                        mem_read_request;
  logic                        mem_write_request;
  logic [sacr_pkg::HIT_W-1:0]  hit_total;

  modport source (output valid, hit, read_data, way_used, mem_read_request,
                  mem_write_request, hit_total, input ready);
  modport sink (input valid, hit, read_data, way_used, mem_read_request,
                mem_write_request, hit_total, output ready);
endinterface

FILE: hdl/set_assoc_cache_random_replace.sv
// Set-associative, write-through cache with random replacement that takes one read or
// write request at a time and returns one result per request. Each request reads the
// set's tag row from a single-port tag RAM on acceptance, then compares, updates the row
// and accesses the data RAM, and then registers the data word once the output register
// is free. A result waits in an output register until it is taken.
// After reset the block runs a clearing pass over the tag and data RAMs and accepts no
// request until all 2**(SET_BITS + clog2(WAYS) + OFFSET_BITS) data RAM words (8192 with
// the defaults) are cleared; writes to the seed register are taken at any time.
module set_assoc_cache_random_replace #(
  parameter int WAYS = 8,
  parameter int SET_BITS = 6,
  parameter int OFFSET_BITS = 4,
  parameter int ADDR_BITS = 40,
  parameter int DATA_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sacr_req_if.sink                    in_req,
  sacr_rsp_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic [sacr_pkg::LFSR_W-1:0] cfg_wdata
);

  localparam int WAY_W   = $clog2(WAYS);
  localparam int TAG_W   = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int ENT_W   = TAG_W + 1;
  localparam int ROW_W   = WAYS * ENT_W;
  localparam int DATA_AW = SET_BITS + WAY_W + OFFSET_BITS;
  localparam logic [ROW_W-1:0] ROW_RESET = {WAYS{1'b0, {TAG_W{1'b1}}}};

  sacr_pkg::state_t state_r, state_nxt;
  logic [DATA_AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                   op_r;
  logic [TAG_W-1:0]       tag_r;
  logic [SET_BITS-1:0]    set_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic [DATA_BITS-1:0]   wdata_r;
  logic                   hit_r;
  logic [WAY_W-1:0]       way_r;
  logic [sacr_pkg::HIT_W-1:0] hit_cnt_r, hit_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r;
  logic [DATA_BITS-1:0]   out_rdata_r;
  logic [2:0]             out_way_r;
  logic                   out_rd_req_r;
  logic                   out_wr_req_r;
  logic [sacr_pkg::HIT_W-1:0] out_total_r;

  logic                   accept;
  logic                   load_out;

  logic [SET_BITS-1:0]    tag_addr;
  logic                   tag_we;
  logic                   tag_re;
  logic [ROW_W-1:0]       tag_wdata;
  logic [ROW_W-1:0]       tag_rdata;
  logic [DATA_AW-1:0]     data_addr;
  logic                   data_we;
  logic                   data_re;
  logic [DATA_BITS-1:0]   data_wdata;
  logic [DATA_BITS-1:0]   data_rdata;

  logic [TAG_W-1:0]       row_tag [WAYS];
  logic [WAYS-1:0]        row_vld;
  logic [WAYS-1:0]        match;
  logic [WAYS-1:0]        same_tag;
  logic                   hit;
  logic                   reuse;
  logic [WAY_W-1:0]       way_hit;
  logic [WAY_W-1:0]       way_reuse;
  logic [WAY_W-1:0]       way_sel;
  logic [WAY_W-1:0]       victim;
  logic                   read_miss;
  logic [ROW_W-1:0]       row_nxt;
  logic [WAY_W+2:0]       way_ext;

  sacr_pkg::victim_ctl_t  victim_ctl;

  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == sacr_pkg::ST_IDLE);
  assign load_out     = (state_r == sacr_pkg::ST_DATA) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_tag[w]  = tag_rdata[w*ENT_W +: TAG_W];
      row_vld[w]  = tag_rdata[w*ENT_W + TAG_W];
      same_tag[w] = (row_tag[w] == tag_r);
      match[w]    = row_vld[w] && same_tag[w];
    end
    way_hit   = '0;
    way_reuse = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        way_hit = WAY_W'(w);
      end
      if (same_tag[w]) begin
        way_reuse = WAY_W'(w);
      end
    end
    hit       = |match;
    reuse     = |same_tag;
    read_miss = !hit && (op_r == sacr_pkg::OP_READ);
    priority if (hit) begin
      way_sel = way_hit;
    end else if (!read_miss) begin
      way_sel = '0;
    end else if (reuse) begin
      way_sel = way_reuse;
    end else begin
      way_sel = victim;
    end
    row_nxt = tag_rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (reuse) begin
        if (same_tag[w]) begin
          row_nxt[w*ENT_W + TAG_W] = 1'b1;
        end
      end else if (victim == WAY_W'(w)) begin
        row_nxt[w*ENT_W +: ENT_W] = {1'b1, tag_r};
      end
    end
  end

  assign victim_ctl.load = cfg_we;
  assign victim_ctl.step = (state_r == sacr_pkg::ST_LOOKUP) && read_miss && !reuse;

  sacr_victim #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_victim (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (victim_ctl),
    .seed   (cfg_wdata),
    .victim (victim)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    hit_cnt_nxt = hit_cnt_r;
    tag_addr    = in_req.address[OFFSET_BITS +: SET_BITS];
    tag_we      = 1'b0;
    tag_re      = 1'b0;
    tag_wdata   = row_nxt;
    data_addr   = {set_r, way_hit, off_r};
    data_we     = 1'b0;
    data_re     = 1'b0;
    data_wdata  = wdata_r;
    unique case (state_r)
      sacr_pkg::ST_CLEAR: begin
        tag_addr    = clr_cnt_r[SET_BITS-1:0];
        tag_we      = 1'b1;
        tag_wdata   = ROW_RESET;
        data_addr   = clr_cnt_r;
        data_we     = 1'b1;
        data_wdata  = '1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = sacr_pkg::ST_IDLE;
        end
      end
      sacr_pkg::ST_IDLE: begin
        tag_re = accept;
        if (accept) begin
          state_nxt = sacr_pkg::ST_LOOKUP;
        end
      end
      sacr_pkg::ST_LOOKUP: begin
        tag_addr = set_r;
        tag_we   = read_miss;
        data_re  = 1'b1;
        data_we  = hit && (op_r == sacr_pkg::OP_WRITE);
        if (hit && (hit_cnt_r != sacr_pkg::HIT_MAX)) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
        end
        state_nxt = sacr_pkg::ST_DATA;
      end
      sacr_pkg::ST_DATA: begin
        if (load_out) begin
          state_nxt = sacr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sacr_pkg::ST_CLEAR;
      end
    endcase
  end

  sacr_spram #(
    .WIDTH (ROW_W),
    .AW    (SET_BITS)
  ) u_tag_ram (
    .clk   (clk),
    .addr  (tag_addr),
    .we    (tag_we),
    .re    (tag_re),
    .wdata (tag_wdata),
    .rdata (tag_rdata)
  );

  sacr_spram #(
    .WIDTH (DATA_BITS),
    .AW    (DATA_AW)
  ) u_data_ram (
    .clk   (clk),
    .addr  (data_addr),
    .we    (data_we),
    .re    (data_re),
    .wdata (data_wdata),
    .rdata (data_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign way_ext = (WAY_W + 3)'(way_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sacr_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_req.op;
      tag_r   <= in_req.address[ADDR_BITS-1:OFFSET_BITS+SET_BITS];
      set_r   <= in_req.address[OFFSET_BITS +: SET_BITS];
      off_r   <= in_req.address[OFFSET_BITS-1:0];
      wdata_r <= in_req.write_data;
    end
    if (state_r == sacr_pkg::ST_LOOKUP) begin
      hit_r <= hit;
      way_r <= way_sel;
    end
    if (load_out) begin
      out_hit_r    <= hit_r;
      out_rdata_r  <= (hit_r && (op_r == sacr_pkg::OP_READ)) ? data_rdata : '0;
      out_way_r    <= way_ext[2:0];
      out_rd_req_r <= !hit_r && (op_r == sacr_pkg::OP_READ);
      out_wr_req_r <= (op_r == sacr_pkg::OP_WRITE);
      out_total_r  <= hit_cnt_r;
    end
  end

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.hit               = out_hit_r;
  assign out_rsp.read_data         = out_rdata_r;
  assign out_rsp.way_used          = out_way_r;
  assign out_rsp.mem_read_request  = out_rd_req_r;
  assign out_rsp.mem_write_request = out_wr_req_r;
  assign out_rsp.hit_total         = out_total_r;

  a_hit_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> hit_cnt_r >= $past(hit_cnt_r))
    else $error("hit counter decreased");

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == sacr_pkg::ST_LOOKUP)
    else $error("accepted request did not start a tag lookup");

  a_tag_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    tag_we |-> (state_r == sacr_pkg::ST_CLEAR) || (state_r == sacr_pkg::ST_LOOKUP))
    else $error("tag RAM written outside clearing or lookup");

  a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> $past(state_r) == sacr_pkg::ST_LOOKUP || $past(state_r) == sacr_pkg::ST_DATA)
    else $error("result loaded without a preceding lookup");

endmodule

FILE: hdl/sacr_spram.sv
module sacr_spram #(
  parameter int WIDTH = 32,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic             re,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/sacr_victim.sv
module sacr_victim #(
  parameter int WAYS = 8,
  parameter int WAY_W = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sacr_pkg::victim_ctl_t         ctl,
  input  logic [sacr_pkg::LFSR_W-1:0]   seed,
  output logic [WAY_W-1:0]              victim
);

  localparam int K = 256 % WAYS;

  function automatic logic [1023:0] mod_lut_f();
    logic [1023:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i*4 +: 4] = 4'(i % WAYS);
    end
    return t;
  endfunction

  localparam logic [1023:0] MOD_LUT = mod_lut_f();

  logic [sacr_pkg::LFSR_W-1:0] lfsr_r;
  logic [sacr_pkg::LFSR_W-1:0] lfsr_nxt;
  logic [sacr_pkg::LFSR_W-1:0] stepped;
  logic [3:0]                  res_hi;
  logic [3:0]                  res_lo;
  logic [7:0]                  res_sum;
  logic [3:0]                  res;

  assign stepped = (lfsr_r >> 1) ^ (lfsr_r[0] ? sacr_pkg::LFSR_TAPS : '0);

  // The residue of the stepped value is built from the residues of its two bytes.
  assign res_hi  = MOD_LUT[stepped[15:8]*4 +: 4];
  assign res_lo  = MOD_LUT[stepped[7:0]*4 +: 4];
  assign res_sum = 8'(res_hi * K) + 8'(res_lo);
  assign res     = MOD_LUT[res_sum*4 +: 4];
  assign victim  = res[WAY_W-1:0];

  always_comb begin
    priority if (ctl.load) begin
      lfsr_nxt = seed;
    end else if (ctl.step) begin
      lfsr_nxt = stepped;
    end else begin
      lfsr_nxt = lfsr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= sacr_pkg::SEED_RESET;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule
